### rtl/assert_macros.svh
// assertion macros included by the sequencer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a fixed message
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// clocked assertion with reset disable and a caller message
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

### rtl/bps_pkg.sv
// shared types and constants of the biphasic pulse sequencer
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int PULSE_COUNT_DEF  = 10;
    localparam int PHASES_PER_PULSE = 4;
    localparam logic [31:0] FILL_RESET = 32'd5000;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 4;
    localparam int TIME_W  = 32;
    localparam int POS_W   = 6;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

    typedef struct packed {
        logic             high_drive;
        logic             low_drive;
        logic             busy_res;
        logic             train_done;
        logic [POS_W-1:0] phase_position;
    } t_result;

endpackage

`default_nettype wire

### rtl/bps_if.sv
// valid/ready channel interfaces for input and result words
`timescale 1ns / 1ps
`default_nettype none

interface bps_in_if;
    logic                         valid;
    logic                         ready;
    logic [bps_pkg::KIND_W-1:0]   kind;
    logic [bps_pkg::INDEX_W-1:0]  pulse_index;
    logic [bps_pkg::TIME_W-1:0]   high_side_time;
    logic [bps_pkg::TIME_W-1:0]   low_side_time;
    logic [bps_pkg::TIME_W-1:0]   gap_time;

    modport source (output valid, kind, pulse_index, high_side_time, low_side_time,
                    gap_time, input ready);
    modport sink   (input valid, kind, pulse_index, high_side_time, low_side_time,
                    gap_time, output ready);
endinterface

interface bps_out_if;
    logic                       valid;
    logic                       ready;
    logic                       high_drive;
    logic                       low_drive;
    logic                       busy_res;
    logic                       train_done;
    logic [bps_pkg::POS_W-1:0]  phase_position;

    modport source (output valid, high_drive, low_drive, busy_res, train_done,
                    phase_position, input ready);
    modport sink   (input valid, high_drive, low_drive, busy_res, train_done,
                    phase_position, output ready);
endinterface

`default_nettype wire

### rtl/bps_out_stage.sv
// result register that holds one word until the sink takes it
`timescale 1ns / 1ps
`default_nettype none

module bps_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire bps_pkg::t_result i_result,
    output logic                  o_free,
    bps_out_if.source             o_out
);

    logic             r_valid;
    bps_pkg::t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.high_drive     = r_result.high_drive;
    assign o_out.low_drive      = r_result.low_drive;
    assign o_out.busy_res       = r_result.busy_res;
    assign o_out.train_done     = r_result.train_done;
    assign o_out.phase_position = r_result.phase_position;

endmodule

`default_nettype wire

### rtl/biphasic_pulse_sequencer_core.sv
// Biphasic pulse sequencer: the pulse train lives in one store of 4*PULSE_COUNT
// duration words (high on, dead, low on, dead per pulse), with one write port and
// one registered read port. Items are handled one at a time; from acceptance to
// the result entering the output register, a tick without a phase change and a
// load with an index past the train go straight to emit, a tick that moves to
// the next phase and a start read the store and use the word, a load makes four
// store writes, and a clear writes the whole store (one store word per cycle).
// A new word is taken the cycle after the result is registered, even while that
// result still waits. The user must write the fill value on the config port only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module biphasic_pulse_sequencer_core #(
    parameter int PULSE_COUNT = bps_pkg::PULSE_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [bps_pkg::TIME_W-1:0]  i_cfg_data,
    bps_in_if.sink                           i_in,
    bps_out_if.source                        o_out
);

    localparam int STORE_SIZE = PULSE_COUNT * bps_pkg::PHASES_PER_PULSE;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PTR_W      = $clog2(STORE_SIZE + 1);
    localparam int TW         = bps_pkg::TIME_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FILL = 5'b00010,
        S_READ = 5'b00100,
        S_USE  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [TW-1:0]     r_count, n_count;
    logic              r_in_gap, n_in_gap;
    logic              r_last_high, n_last_high;
    logic              r_running, n_running;
    logic              r_done, n_done;
    logic              r_clear, n_clear;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [TW-1:0]     r_hi, n_hi;
    logic [TW-1:0]     r_lo, n_lo;
    logic [TW-1:0]     r_gap, n_gap;
    logic [TW-1:0]     r_fill;

    logic [TW-1:0]     r_mem [STORE_SIZE];
    logic [TW-1:0]     r_rdata;
    logic              w_we;
    logic [TW-1:0]     w_wdata;

    logic              w_accept;
    logic              w_free;
    logic              w_load_out;
    logic [TW-1:0]     w_dec;
    logic [PTR_W-1:0]  w_ptr_inc;
    logic [31:0]       w_base;
    logic [31:0]       w_pos_ext;
    logic              w_fill_last;
    bps_pkg::t_result  w_result;

    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= bps_pkg::FILL_RESET;
        end else if (i_cfg_we) begin
            r_fill <= i_cfg_data;
        end
    end

    // store port: up to one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_rd_addr];
    end

    assign w_we = (r_state == S_FILL);

    always_comb begin
        if (r_clear) begin
            w_wdata = r_fill;
        end else begin
            case (r_wr_addr[1:0])
                2'd0:    w_wdata = r_hi;
                2'd2:    w_wdata = r_lo;
                default: w_wdata = r_gap;
            endcase
        end
    end

    // a load ends on the fourth word of its pulse, a clear on the last entry
    assign w_fill_last = r_clear ? (r_wr_addr == ADDR_W'(STORE_SIZE - 1))
                                 : (r_wr_addr[1:0] == 2'b11);

    assign w_dec     = (r_count != '0) ? (r_count - TW'(1)) : '0;
    assign w_ptr_inc = r_ptr + PTR_W'(1);
    assign w_base    = {26'd0, i_in.pulse_index, 2'b00};

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_in_gap    = r_in_gap;
        n_last_high = r_last_high;
        n_running   = r_running;
        n_done      = r_done;
        n_clear     = r_clear;
        n_wr_addr   = r_wr_addr;
        n_rd_addr   = r_rd_addr;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_gap       = r_gap;
        w_load_out  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_done = 1'b0;
                    n_hi   = i_in.high_side_time;
                    n_lo   = i_in.low_side_time;
                    n_gap  = i_in.gap_time;
                    case (i_in.kind)
                        bps_pkg::KIND_LOAD: begin
                            if ({28'd0, i_in.pulse_index} < 32'(PULSE_COUNT)) begin
                                n_wr_addr = w_base[ADDR_W-1:0];
                                n_clear   = 1'b0;
                                n_state   = S_FILL;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        bps_pkg::KIND_START: begin
                            n_ptr       = '0;
                            n_in_gap    = 1'b0;
                            n_last_high = 1'b1;
                            n_running   = 1'b1;
                            n_rd_addr   = '0;
                            n_state     = S_READ;
                        end
                        bps_pkg::KIND_CLEAR: begin
                            n_running = 1'b0;
                            n_ptr     = '0;
                            n_count   = '0;
                            n_in_gap  = 1'b1;
                            n_wr_addr = '0;
                            n_clear   = 1'b1;
                            n_state   = S_FILL;
                        end
                        default: begin
                            n_state = S_EMIT;
                            if (r_running) begin
                                n_count = w_dec;
                                if (w_dec == '0) begin
                                    if (w_ptr_inc >= PTR_W'(STORE_SIZE)) begin
                                        n_ptr     = PTR_W'(STORE_SIZE);
                                        n_running = 1'b0;
                                        n_in_gap  = 1'b1;
                                        n_done    = 1'b1;
                                    end else begin
                                        n_ptr     = w_ptr_inc;
                                        n_rd_addr = w_ptr_inc[ADDR_W-1:0];
                                        n_state   = S_READ;
                                        if (!r_in_gap) begin
                                            n_in_gap = 1'b1;
                                        end else begin
                                            n_in_gap    = 1'b0;
                                            n_last_high = !r_last_high;
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (w_fill_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_wr_addr = r_wr_addr + ADDR_W'(1);
                end
            end
            S_READ: begin
                n_state = S_USE;
            end
            S_USE: begin
                // a stored zero is timed as one tick
                n_count = (r_rdata == '0) ? TW'(1) : r_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_count     <= '0;
            r_in_gap    <= 1'b1;
            r_last_high <= 1'b0;
            r_running   <= 1'b0;
            r_done      <= 1'b0;
            r_clear     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_in_gap    <= n_in_gap;
            r_last_high <= n_last_high;
            r_running   <= n_running;
            r_done      <= n_done;
            r_clear     <= n_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_rd_addr <= n_rd_addr;
        r_hi      <= n_hi;
        r_lo      <= n_lo;
        r_gap     <= n_gap;
    end

    assign w_pos_ext = 32'(r_ptr);

    assign w_result.high_drive     = r_running && !r_in_gap && r_last_high;
    assign w_result.low_drive      = r_running && !r_in_gap && !r_last_high;
    assign w_result.busy_res       = r_running;
    assign w_result.train_done     = r_done;
    assign w_result.phase_position = w_pos_ext[bps_pkg::POS_W-1:0];

    bps_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load_out),
        .i_result (w_result),
        .o_free   (w_free),
        .o_out    (o_out)
    );

    `ASSERT_CLK_MSG(a_ptr_in_store, i_clk, i_rst_n,
        r_running |-> (r_ptr < PTR_W'(STORE_SIZE)), "running pointer past store")
    `ASSERT_CLK_MSG(a_done_stops, i_clk, i_rst_n,
        (r_state == S_EMIT && r_done) |-> !r_running, "done flagged while running")
    `ASSERT_CLK(a_use_after_read, i_clk, i_rst_n,
        (r_state == S_USE) |-> ($past(r_state) == S_READ))
    `ASSERT_CLK_MSG(a_count_live, i_clk, i_rst_n,
        (r_state == S_IDLE && r_running) |-> (r_count != '0), "running with no count")

endmodule

`default_nettype wire
